/* hdl/mie_pkg.sv */
// Shared types and constants for the MIPS integer execute unit.
package mie_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int REG_COUNT  = 32;
  localparam int REG_AW     = 5;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = 1;
  localparam int HALF_SHIFT = 16;
  localparam logic [REG_AW-1:0] LINK_REG = 5'd31;
  localparam logic [31:0] SEG_MASK = 32'hF000_0000;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_BLEZ    = 6'h06;
  localparam logic [5:0] OPC_BGTZ    = 6'h07;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0A;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_BEQL    = 6'h14;
  localparam logic [5:0] OPC_BNEL    = 6'h15;
  localparam logic [5:0] OPC_BLEZL   = 6'h16;
  localparam logic [5:0] OPC_BGTZL   = 6'h17;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  typedef enum logic [5:0] {
    OP_BAD, OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_JR, OP_JALR,
    OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT, OP_MULTU, OP_DIV, OP_DIVU,
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
    OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_J, OP_JAL, OP_BEQ, OP_BNE,
    OP_BLEZ, OP_BGTZ, OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
    OP_LUI
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [4:0]       rs;
    logic [4:0]       rt;
    logic [4:0]       dst;
    logic [4:0]       sa;
    logic [15:0]      imm;
    logic [31:0]      link;
    logic [31:0]      btarget;
    logic [31:0]      jtarget;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DFIN
  } st_t;

endpackage

/* hdl/mips_integer_execute_unit.sv */
// Top level: MIPS I integer execute unit with register file and HI/LO.
// Flow: an accepted word passes through the queue, then queue pop with register read, then execute.
// Execute registers the result and waits while the output is stalled; the back end takes no new word
// until its read-then-execute sequence ends. mult/multu add a multiply state, div/divu the radix-2 divider.
// Reset: synchronous active-low rst_n clears the queue, control state, HI, LO and
// the register file valid bits, so every register reads as zero after reset.
module mips_integer_execute_unit
  import mie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_instr_pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [4:0]  out_write_index,
  output logic [31:0] out_write_data,
  output logic        out_redirect,
  output logic [31:0] out_redirect_target,
  output logic        out_status
);

  uop_t dec_uop;
  uop_t head_uop;
  logic q_full;
  logic q_valid;
  logic q_pop;

  mie_front u_front (
    .instr_word(in_instr_word),
    .instr_pc(in_instr_pc),
    .uop(dec_uop)
  );

  mie_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(in_valid),
    .push_uop(dec_uop),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_uop(head_uop)
  );

  assign in_ready = !q_full;

  mie_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_uop(head_uop),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_write_enable(out_write_enable),
    .out_write_index(out_write_index),
    .out_write_data(out_write_data),
    .out_redirect(out_redirect),
    .out_redirect_target(out_redirect_target),
    .out_status(out_status)
  );

endmodule

/* hdl/mie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mie_front.sv */
// Front end: decodes an instruction word into an operation record with targets.
module mie_front
  import mie_pkg::*;
(
  input  logic [31:0] instr_word,
  input  logic [31:0] instr_pc,
  output uop_t        uop
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [31:0] pc4;
  logic [31:0] simm;
  op_t         op;
  logic [4:0]  dst;

  assign opc  = instr_word[31:26];
  assign fn   = instr_word[5:0];
  assign pc4  = instr_pc + 32'd4;
  assign simm = {{16{instr_word[15]}}, instr_word[15:0]};

  always_comb begin
    op  = OP_BAD;
    dst = instr_word[20:16];
    case (opc)
      OPC_SPECIAL: begin
        dst = instr_word[15:11];
        case (fn)
          FN_SLL:   op = OP_SLL;
          FN_SRL:   op = OP_SRL;
          FN_SRA:   op = OP_SRA;
          FN_SLLV:  op = OP_SLLV;
          FN_SRLV:  op = OP_SRLV;
          FN_SRAV:  op = OP_SRAV;
          FN_JR:    op = OP_JR;
          FN_JALR:  op = OP_JALR;
          FN_MFHI:  op = OP_MFHI;
          FN_MTHI:  op = OP_MTHI;
          FN_MFLO:  op = OP_MFLO;
          FN_MTLO:  op = OP_MTLO;
          FN_MULT:  op = OP_MULT;
          FN_MULTU: op = OP_MULTU;
          FN_DIV:   op = OP_DIV;
          FN_DIVU:  op = OP_DIVU;
          FN_ADD, FN_ADDU: op = OP_ADD;
          FN_SUB, FN_SUBU: op = OP_SUB;
          FN_AND:   op = OP_AND;
          FN_OR:    op = OP_OR;
          FN_XOR:   op = OP_XOR;
          FN_NOR:   op = OP_NOR;
          FN_SLT:   op = OP_SLT;
          FN_SLTU:  op = OP_SLTU;
          default:  op = OP_BAD;
        endcase
      end
      OPC_REGIMM: begin
        dst = LINK_REG;
        case (instr_word[20:16])
          RI_BLTZ:   op = OP_BLTZ;
          RI_BGEZ:   op = OP_BGEZ;
          RI_BLTZAL: op = OP_BLTZAL;
          RI_BGEZAL: op = OP_BGEZAL;
          default:   op = OP_BAD;
        endcase
      end
      OPC_J:   op = OP_J;
      OPC_JAL: begin
        op  = OP_JAL;
        dst = LINK_REG;
      end
      OPC_BEQ, OPC_BEQL:   op = OP_BEQ;
      OPC_BNE, OPC_BNEL:   op = OP_BNE;
      OPC_BLEZ, OPC_BLEZL: op = OP_BLEZ;
      OPC_BGTZ, OPC_BGTZL: op = OP_BGTZ;
      OPC_ADDI, OPC_ADDIU: op = OP_ADDI;
      OPC_SLTI:  op = OP_SLTI;
      OPC_SLTIU: op = OP_SLTIU;
      OPC_ANDI:  op = OP_ANDI;
      OPC_ORI:   op = OP_ORI;
      OPC_XORI:  op = OP_XORI;
      OPC_LUI:   op = OP_LUI;
      default:   op = OP_BAD;
    endcase
  end

  always_comb begin
    uop.op      = op;
    uop.rs      = instr_word[25:21];
    uop.rt      = instr_word[20:16];
    uop.dst     = dst;
    uop.sa      = instr_word[10:6];
    uop.imm     = instr_word[15:0];
    uop.link    = instr_pc + 32'd8;
    uop.btarget = pc4 + {simm[29:0], 2'b00};
    uop.jtarget = (pc4 & SEG_MASK) | {4'b0000, instr_word[25:0], 2'b00};
  end

endmodule

/* hdl/mie_queue.sv */
// Short queue of decoded operations between front end and back end.
module mie_queue
  import mie_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  uop_t push_uop,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output uop_t head_uop
);

  uop_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_uop   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_uop;
    end
  end

endmodule

/* hdl/mie_back.sv */
// Back end: register file, HI/LO, multiplier, iterative divider and result register.
module mie_back
  import mie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  uop_t        q_uop,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [4:0]  out_write_index,
  output logic [31:0] out_write_data,
  output logic        out_redirect,
  output logic [31:0] out_redirect_target,
  output logic        out_status
);

  st_t           state_r, state_nxt;
  uop_t          uop_r;
  logic [REG_COUNT-1:0] valid_r;
  logic [31:0]   ram_a, ram_b;
  logic [31:0]   a, b, simm, zimm;
  logic          go;
  logic          wr, redir, bad, start_mul, start_div;
  logic [4:0]    dst;
  logic [31:0]   val, tgt;
  logic          ram_we;
  logic [31:0]   hi_r, lo_r, hi_nxt, lo_nxt;
  logic [31:0]   opa_r, opb_r;
  logic          msgn_r;
  logic [63:0]   prod;
  logic [31:0]   rem_r, quo_r, den_r;
  logic [4:0]    dcnt_r;
  logic          neg_q_r, neg_r_r;
  logic [32:0]   dshift, ddiff;
  logic [31:0]   amag, bmag;
  logic          sgn_div;
  logic          out_valid_r;
  logic          oen_r, ored_r, ost_r;
  logic [4:0]    oidx_r;
  logic [31:0]   odat_r, otgt_r;

  mie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_a (
    .clk(clk), .we(ram_we), .waddr(dst), .wdata(val),
    .re(q_pop), .raddr(q_uop.rs), .rdata(ram_a)
  );

  mie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_b (
    .clk(clk), .we(ram_we), .waddr(dst), .wdata(val),
    .re(q_pop), .raddr(q_uop.rt), .rdata(ram_b)
  );

  assign a     = valid_r[uop_r.rs] ? ram_a : '0;
  assign b     = valid_r[uop_r.rt] ? ram_b : '0;
  assign simm  = {{16{uop_r.imm[15]}}, uop_r.imm};
  assign zimm  = {16'h0000, uop_r.imm};
  assign go    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (go) begin
          if (start_mul) begin
            state_nxt = ST_MUL;
          end else if (start_div && b != '0) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MUL:  state_nxt = ST_IDLE;
      ST_DIV:  if (dcnt_r == 5'd31) state_nxt = ST_DFIN;
      ST_DFIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wr        = 1'b0;
    redir     = 1'b0;
    bad       = 1'b0;
    start_mul = 1'b0;
    start_div = 1'b0;
    dst       = uop_r.dst;
    val       = '0;
    tgt       = uop_r.btarget;
    case (uop_r.op)
      OP_SLL:  begin wr = 1'b1; val = b << uop_r.sa; end
      OP_SRL:  begin wr = 1'b1; val = b >> uop_r.sa; end
      OP_SRA:  begin wr = 1'b1; val = 32'($signed(b) >>> uop_r.sa); end
      OP_SLLV: begin wr = 1'b1; val = b << a[4:0]; end
      OP_SRLV: begin wr = 1'b1; val = b >> a[4:0]; end
      OP_SRAV: begin wr = 1'b1; val = 32'($signed(b) >>> a[4:0]); end
      OP_JR:   begin redir = 1'b1; tgt = a; end
      OP_JALR: begin wr = 1'b1; val = uop_r.link; redir = 1'b1; tgt = a; end
      OP_MFHI: begin wr = 1'b1; val = hi_r; end
      OP_MFLO: begin wr = 1'b1; val = lo_r; end
      OP_MTHI, OP_MTLO: ;
      OP_MULT, OP_MULTU: start_mul = 1'b1;
      OP_DIV, OP_DIVU:   start_div = 1'b1;
      OP_ADD:  begin wr = 1'b1; val = a + b; end
      OP_SUB:  begin wr = 1'b1; val = a - b; end
      OP_AND:  begin wr = 1'b1; val = a & b; end
      OP_OR:   begin wr = 1'b1; val = a | b; end
      OP_XOR:  begin wr = 1'b1; val = a ^ b; end
      OP_NOR:  begin wr = 1'b1; val = ~(a | b); end
      OP_SLT:  begin wr = 1'b1; val = {31'd0, $signed(a) < $signed(b)}; end
      OP_SLTU: begin wr = 1'b1; val = {31'd0, a < b}; end
      OP_BLTZ: redir = a[31];
      OP_BGEZ: redir = !a[31];
      OP_BLTZAL: begin redir = a[31]; wr = 1'b1; val = uop_r.link; end
      OP_BGEZAL: begin redir = !a[31]; wr = 1'b1; val = uop_r.link; end
      OP_J:    begin redir = 1'b1; tgt = uop_r.jtarget; end
      OP_JAL:  begin redir = 1'b1; tgt = uop_r.jtarget; wr = 1'b1; val = uop_r.link; end
      OP_BEQ:  redir = (a == b);
      OP_BNE:  redir = (a != b);
      OP_BLEZ: redir = (a == '0) || a[31];
      OP_BGTZ: redir = (a != '0) && !a[31];
      OP_ADDI: begin wr = 1'b1; val = a + simm; end
      OP_SLTI: begin wr = 1'b1; val = {31'd0, $signed(a) < $signed(simm)}; end
      OP_SLTIU: begin wr = 1'b1; val = {31'd0, a < simm}; end
      OP_ANDI: begin wr = 1'b1; val = a & zimm; end
      OP_ORI:  begin wr = 1'b1; val = a | zimm; end
      OP_XORI: begin wr = 1'b1; val = a ^ zimm; end
      OP_LUI:  begin wr = 1'b1; val = zimm << HALF_SHIFT; end
      default: bad = 1'b1;
    endcase
    if (dst == '0) wr = 1'b0;
    if (!wr) begin
      dst = '0;
      val = '0;
    end
    if (!redir) tgt = '0;
  end

  assign ram_we  = go && wr;
  assign sgn_div = (uop_r.op == OP_DIV);
  assign amag    = (sgn_div && a[31]) ? -a : a;
  assign bmag    = (sgn_div && b[31]) ? -b : b;
  assign prod    = 64'($signed({msgn_r & opa_r[31], opa_r}) *
                       $signed({msgn_r & opb_r[31], opb_r}));
  assign dshift  = {rem_r, quo_r[31]};
  assign ddiff   = dshift - {1'b0, den_r};

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    case (state_r)
      ST_EXEC: begin
        if (go && uop_r.op == OP_MTHI) hi_nxt = a;
        if (go && uop_r.op == OP_MTLO) lo_nxt = a;
        if (go && start_div && b == '0) begin
          hi_nxt = a;
          lo_nxt = '1;
        end
      end
      ST_MUL: begin
        hi_nxt = prod[63:32];
        lo_nxt = prod[31:0];
      end
      ST_DFIN: begin
        lo_nxt = neg_q_r ? -quo_r : quo_r;
        hi_nxt = neg_r_r ? -rem_r : rem_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      if (ram_we) valid_r[dst] <= 1'b1;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) uop_r <= q_uop;
    if (go) begin
      oen_r  <= wr;
      oidx_r <= dst;
      odat_r <= val;
      ored_r <= redir && !bad;
      otgt_r <= tgt;
      ost_r  <= bad;
      opa_r  <= a;
      opb_r  <= b;
      msgn_r <= (uop_r.op == OP_MULT);
      rem_r  <= '0;
      quo_r  <= amag;
      den_r  <= bmag;
      dcnt_r <= '0;
      neg_q_r <= sgn_div && (a[31] ^ b[31]);
      neg_r_r <= sgn_div && a[31];
    end else if (state_r == ST_DIV) begin
      rem_r  <= ddiff[32] ? dshift[31:0] : ddiff[31:0];
      quo_r  <= {quo_r[30:0], ~ddiff[32]};
      dcnt_r <= dcnt_r + 5'd1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_write_enable    = oen_r;
  assign out_write_index     = oidx_r;
  assign out_write_data      = odat_r;
  assign out_redirect        = ored_r;
  assign out_redirect_target = otgt_r;
  assign out_status          = ost_r;

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !q_pop) else $error("pop while busy");
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (dst != '0)) else $error("write to r0");
  a_div_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_DFIN))
    else $error("divider left early");
  a_exec_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_EXEC)) else $error("pop without execute");

endmodule
